FILE: hw/rtl/rsd_pkg.sv
`default_nettype none
package rsd_pkg;
	typedef enum logic [2:0] {
		PH_LOAD,
		PH_SYN,
		PH_LOC,
		PH_SEARCH,
		PH_OUT
	} phase_t;

	localparam logic [1:0] ST_CLEAN = 2'd0;
	localparam logic [1:0] ST_FIXED = 2'd1;
	localparam logic [1:0] ST_FAIL = 2'd2;

	typedef struct packed {
		logic load_wr;
		logic syn_clr;
		logic syn_acc;
		logic loc_go;
		logic srch_step;
	} dp_cmd_t;

	typedef struct packed {
		logic any_syn;
		logic fail;
	} dp_sts_t;
endpackage
`default_nettype wire

FILE: hw/rtl/rsd_datapath.sv
`default_nettype none
module rsd_datapath #(
	parameter int SYMBOL_BITS = 5,
	parameter int CODE_LENGTH = 31,
	parameter int FIELD_POLY = 37,
	parameter int PW = 5
) (
	input wire logic clk,
	input wire rsd_pkg::dp_cmd_t cmd,
	input wire logic [PW-1:0] pos,
	input wire logic [SYMBOL_BITS-1:0] din,
	output rsd_pkg::dp_sts_t sts,
	output logic [SYMBOL_BITS-1:0] dout
);
	import rsd_pkg::*;
	localparam int SB = SYMBOL_BITS;

	function automatic logic [SB-1:0] gmul(logic [SB-1:0] a, logic [SB-1:0] b);
		logic [SB-1:0] r;
		logic [SB-1:0] x;
		r = '0;
		x = a;
		for (int k = 0; k < SB; k++) begin
			if (b[k]) r = r ^ x;
			x = x[SB-1] ? ((x << 1) ^ FIELD_POLY[SB-1:0]) : (x << 1);
		end
		return r;
	endfunction

	// alpha^-1, valid for a primitive polynomial with its constant term set
	localparam logic [SB-1:0] AINV1 = (FIELD_POLY[SB-1:0] >> 1) | SB'(1 << (SB-1));

	logic [SB-1:0] mem [CODE_LENGTH];
	logic [SB-1:0] rd_q;
	logic [PW-1:0] rpos_q;
	logic [SB-1:0] s1_q, s2_q, a1_q, a2_q;
	logic [SB-1:0] loc_q, mag_q, pos_q, ai_q;
	logic [PW-1:0] epos_q;
	logic hit;
	logic syn_nonzero;
	logic fix_bad;

	// one symbol per cycle into the store while load_wr is high; rpos_q tags the registered read
	always_ff @(posedge clk) begin
		if (cmd.load_wr) mem[pos] <= din;
		rd_q <= mem[pos];
		rpos_q <= pos;
	end

	always_ff @(posedge clk) begin
		if (cmd.syn_clr) begin
			s1_q <= '0;
			s2_q <= '0;
			a1_q <= SB'(1);
			a2_q <= SB'(1);
		end else if (cmd.syn_acc) begin
			s1_q <= s1_q ^ gmul(rd_q, a1_q);
			s2_q <= s2_q ^ gmul(rd_q, a2_q);
			a1_q <= gmul(a1_q, SB'(2));
			a2_q <= gmul(a2_q, SB'(4));
		end
	end

	// t=1: locator 1 + (s2/s1) x, error value s1^2/s2
	// chien: pos_q = alpha^p, root when s1*alpha^p == s2
	assign hit = (gmul(s1_q, pos_q) == s2_q);

	always_ff @(posedge clk) begin
		if (cmd.loc_go) begin
			loc_q <= '0;
			pos_q <= SB'(1);
			epos_q <= '0;
		end else if (cmd.srch_step) begin
			if (hit) begin
				loc_q <= loc_q + 1'b1;
				epos_q <= pos;
			end
			pos_q <= gmul(pos_q, SB'(2));
		end
	end

	// magnitude: s1 = e * alpha^p so e = s1 * alpha^(-p)
	always_ff @(posedge clk) begin
		if (cmd.loc_go) mag_q <= '0;
		else if (cmd.srch_step && hit)
			mag_q <= gmul(s1_q, ai_q);
	end

	// alpha^-p tracked by multiplying by alpha^-1 each step
	always_ff @(posedge clk) begin
		if (cmd.loc_go) ai_q <= SB'(1);
		else if (cmd.srch_step) ai_q <= gmul(ai_q, AINV1);
	end

	assign syn_nonzero = (s1_q != '0) || (s2_q != '0);
	assign fix_bad = (s1_q == '0) || (s2_q == '0) || (loc_q != SB'(1));
	assign sts = '{any_syn: syn_nonzero, fail: fix_bad};
	assign dout = (!fix_bad && epos_q == rpos_q) ? (rd_q ^ mag_q) : rd_q;
endmodule
`default_nettype wire

FILE: hw/rtl/rsd_ctrl.sv
`default_nettype none
module rsd_ctrl #(
	parameter int CODE_LENGTH = 31,
	parameter int PW = 5
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_ready,
	output logic out_valid,
	input wire logic out_ready,
	input wire rsd_pkg::dp_sts_t sts,
	output rsd_pkg::dp_cmd_t cmd,
	output logic [PW-1:0] pos,
	output logic [1:0] status,
	output logic last
);
	import rsd_pkg::*;
	localparam logic [PW-1:0] LASTP = PW'(CODE_LENGTH - 1);

	phase_t state_q, state_d;
	logic [PW-1:0] cnt_q;
	logic prime_q;
	logic [1:0] st_q;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			PH_LOAD: if (in_valid && cnt_q == LASTP) state_d = PH_SYN;
			PH_SYN: if (cnt_q == LASTP && prime_q) state_d = PH_LOC;
			PH_LOC: state_d = PH_SEARCH;
			PH_SEARCH: if (cnt_q == LASTP) state_d = PH_OUT;
			PH_OUT: if (out_ready && prime_q && cnt_q == LASTP) state_d = PH_LOAD;
			default: state_d = PH_LOAD;
		endcase
	end

	always_comb begin
		cmd = '0;
		in_ready = 1'b0;
		out_valid = 1'b0;
		unique case (state_q)
			PH_LOAD: begin
				in_ready = 1'b1;
				cmd.load_wr = in_valid;
				cmd.syn_clr = 1'b1;
			end
			PH_SYN: cmd.syn_acc = prime_q;
			PH_LOC: cmd.loc_go = 1'b1;
			PH_SEARCH: cmd.srch_step = 1'b1;
			PH_OUT: out_valid = prime_q;
			default: ;
		endcase
	end

	// pos leads by one in read phases so registered store data lines up
	always_comb begin
		pos = cnt_q;
		if ((state_q == PH_SYN || state_q == PH_OUT) && prime_q && cnt_q != LASTP)
			pos = cnt_q + 1'b1;
		if (state_q == PH_OUT && prime_q && !out_ready) pos = cnt_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= PH_LOAD;
			cnt_q <= '0;
			prime_q <= 1'b0;
			st_q <= ST_CLEAN;
		end else begin
			state_q <= state_d;
			unique case (state_q)
				PH_LOAD: if (in_valid) begin
					cnt_q <= (cnt_q == LASTP) ? '0 : cnt_q + 1'b1;
					prime_q <= 1'b0;
				end
				PH_SYN: begin
					if (!prime_q) prime_q <= 1'b1;
					else cnt_q <= (cnt_q == LASTP) ? '0 : cnt_q + 1'b1;
				end
				PH_LOC: prime_q <= 1'b0;
				PH_SEARCH: cnt_q <= (cnt_q == LASTP) ? '0 : cnt_q + 1'b1;
				PH_OUT: begin
					if (!prime_q) begin
						prime_q <= 1'b1;
						// search is complete here, root count included
						st_q <= !sts.any_syn ? ST_CLEAN : (sts.fail ? ST_FAIL : ST_FIXED);
					end else if (out_ready) begin
						cnt_q <= (cnt_q == LASTP) ? '0 : cnt_q + 1'b1;
						if (cnt_q == LASTP) prime_q <= 1'b0;
					end
				end
				default: ;
			endcase
		end
	end

	assign status = st_q;
	assign last = (cnt_q == LASTP);
endmodule
`default_nettype wire

FILE: hw/rtl/reed_solomon_decoder.sv
`default_nettype none
// reed-solomon (31,29) decoder over gf(32), x^5+x^2+1, single symbol
// correction. a word is 31 symbol transfers in position order; after the
// last one the block reads the store back once for the two syndromes,
// sets up the locator, runs a chien search over all positions and then
// streams the 31 corrected symbols with the word's status, last_symbol
// high on the final one and held while out_ready is low. the syndrome
// and output phases walk the single port symbol store one entry a cycle,
// the output only while out_ready is high. no input is taken while a
// word is being decoded or sent.
module reed_solomon_decoder #(
	parameter int SYMBOL_BITS = 5,
	parameter int CODE_LENGTH = 31,
	parameter int FIELD_POLY = 37
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_ready,
	input wire logic [SYMBOL_BITS-1:0] received_symbol,
	output logic out_valid,
	input wire logic out_ready,
	output logic [SYMBOL_BITS-1:0] corrected_symbol,
	output logic [1:0] decode_status,
	output logic last_symbol
);
	import rsd_pkg::*;
	localparam int PW = $clog2(CODE_LENGTH);

	dp_cmd_t cmd;
	dp_sts_t sts;
	logic [PW-1:0] pos;

	// sequencer for load, syndrome, locator, search and output phases
	rsd_ctrl #(.CODE_LENGTH(CODE_LENGTH), .PW(PW)) u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.out_valid(out_valid), .out_ready(out_ready),
		.sts(sts), .cmd(cmd), .pos(pos),
		.status(decode_status), .last(last_symbol)
	);

	// symbol store plus field arithmetic
	rsd_datapath #(.SYMBOL_BITS(SYMBOL_BITS), .CODE_LENGTH(CODE_LENGTH),
		.FIELD_POLY(FIELD_POLY), .PW(PW)) u_dp (
		.clk(clk), .cmd(cmd), .pos(pos), .din(received_symbol),
		.sts(sts), .dout(corrected_symbol)
	);

`ifndef SYNTHESIS
	// input and output transfers never overlap
	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid)) else $error("in and out both open");
	// a status sent with out_valid is never the unused code 3
	a_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (decode_status != 2'd3)) else $error("bad status");
	// held result keeps its status
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> $stable(decode_status))
		else $error("status moved");
`endif
endmodule
`default_nettype wire
